@@ hdl/qvr_pkg.sv @@
// Shared widths and control types for the quaternion vector rotation pipeline.
// No dependencies; every design module refers to it by scoped names.
package qvr_pkg;

  localparam int QW   = 32;          // quaternion and vector component width
  localparam int PRW  = 2 * QW;      // 32x32 product width
  localparam int TW   = PRW + 2;     // first Hamilton product component width
  localparam int NW   = PRW + 1;     // squared norm width
  localparam int SPL  = 33;          // split point of a first-product component
  localparam int PW   = 100;         // exact width of the rotated numerator
  localparam int MAGW = 98;          // magnitude bits kept before doubling
  localparam int QB   = 33;          // quotient bits resolved by the divider
  localparam int NUMW = MAGW + 1;    // rounded dividend width
  localparam int DW   = NW + 1;      // doubled norm width

  typedef struct packed {
    logic vld;   // stage holds a request
    logic zero;  // quaternion was all zero
  } qvr_ctl_t;

endpackage

@@ hdl/qvr_mult.sv @@
// First two pipeline stages: component products, then the first Hamilton
// product q*(0,v) and the squared norm. Depends on qvr_pkg.
module qvr_mult (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic signed [qvr_pkg::QW-1:0]     q_i [4],
  input  logic signed [qvr_pkg::QW-1:0]     v_i [3],
  output logic signed [qvr_pkg::TW-1:0]     t_o [4],
  output logic        [qvr_pkg::NW-1:0]     n_o,
  output logic signed [qvr_pkg::QW-1:0]     q_o [4],
  output qvr_pkg::qvr_ctl_t                 ctl_o
);

  logic signed [qvr_pkg::PRW-1:0] prod_r [12];
  logic        [qvr_pkg::PRW-1:0] sq_r [4];
  logic signed [qvr_pkg::QW-1:0]  q1_r [4];
  qvr_pkg::qvr_ctl_t              ctl1_r, ctl2_r;
  logic signed [qvr_pkg::TW-1:0]  t_r [4];
  logic        [qvr_pkg::NW-1:0]  n_r;
  logic signed [qvr_pkg::QW-1:0]  q2_r [4];

  // Products in the order the sums below consume them (q index 0 is w).
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0]  <= q_i[1] * v_i[0];
      prod_r[1]  <= q_i[2] * v_i[1];
      prod_r[2]  <= q_i[3] * v_i[2];
      prod_r[3]  <= q_i[0] * v_i[0];
      prod_r[4]  <= q_i[2] * v_i[2];
      prod_r[5]  <= q_i[3] * v_i[1];
      prod_r[6]  <= q_i[0] * v_i[1];
      prod_r[7]  <= q_i[1] * v_i[2];
      prod_r[8]  <= q_i[3] * v_i[0];
      prod_r[9]  <= q_i[0] * v_i[2];
      prod_r[10] <= q_i[1] * v_i[1];
      prod_r[11] <= q_i[2] * v_i[0];
      for (int k = 0; k < 4; k++) begin
        sq_r[k] <= q_i[k] * q_i[k];
        q1_r[k] <= q_i[k];
      end
      ctl1_r.zero <= (q_i[0] == '0) && (q_i[1] == '0) && (q_i[2] == '0) && (q_i[3] == '0);
    end
  end

  // Component 0 is kept un-negated; qvr_rot folds the sign in.
  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= qvr_pkg::TW'(prod_r[0]) + qvr_pkg::TW'(prod_r[1]) + qvr_pkg::TW'(prod_r[2]);
      t_r[1] <= qvr_pkg::TW'(prod_r[3]) + qvr_pkg::TW'(prod_r[4]) - qvr_pkg::TW'(prod_r[5]);
      t_r[2] <= qvr_pkg::TW'(prod_r[6]) - qvr_pkg::TW'(prod_r[7]) + qvr_pkg::TW'(prod_r[8]);
      t_r[3] <= qvr_pkg::TW'(prod_r[9]) + qvr_pkg::TW'(prod_r[10]) - qvr_pkg::TW'(prod_r[11]);
      n_r    <= qvr_pkg::NW'(sq_r[0]) + qvr_pkg::NW'(sq_r[1])
              + qvr_pkg::NW'(sq_r[2]) + qvr_pkg::NW'(sq_r[3]);
      q2_r        <= q1_r;
      ctl2_r.zero <= ctl1_r.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.vld <= 1'b0;
      ctl2_r.vld <= 1'b0;
    end else if (en) begin
      ctl1_r.vld <= in_vld;
      ctl2_r.vld <= ctl1_r.vld;
    end
  end

  assign t_o   = t_r;
  assign n_o   = n_r;
  assign q_o   = q2_r;
  assign ctl_o = ctl2_r;

endmodule

@@ hdl/qvr_rot.sv @@
// Three stages forming the vector part of t*conj(q): split partial products,
// signed terms, and the four-term sums. Depends on qvr_pkg.
module qvr_rot (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic signed [qvr_pkg::TW-1:0] t_i [4],
  input  logic        [qvr_pkg::NW-1:0] n_i,
  input  logic signed [qvr_pkg::QW-1:0] q_i [4],
  input  qvr_pkg::qvr_ctl_t             ctl_i,
  output logic signed [qvr_pkg::PW-1:0] p_o [3],
  output logic        [qvr_pkg::NW-1:0] n_o,
  output qvr_pkg::qvr_ctl_t             ctl_o
);

  // Quaternion component and sign used by term j of output lane l.
  localparam int COEF [3][4] = '{'{1, 0, 3, 2}, '{2, 3, 0, 1}, '{3, 2, 1, 0}};
  localparam bit NEG  [3][4] = '{'{0, 0, 1, 0}, '{0, 0, 0, 1}, '{0, 1, 0, 0}};

  localparam int HW = qvr_pkg::TW - qvr_pkg::SPL;

  logic signed [HW+qvr_pkg::QW-1:0]           ph_r   [3][4];
  logic signed [qvr_pkg::SPL+qvr_pkg::QW:0]   pl_r   [3][4];
  logic signed [qvr_pkg::PW-1:0]              term_r [3][4];
  logic signed [qvr_pkg::PW-1:0]              p_r    [3];
  logic        [qvr_pkg::NW-1:0]              n1_r, n2_r, n3_r;
  qvr_pkg::qvr_ctl_t                          ctl1_r, ctl2_r, ctl3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        for (int j = 0; j < 4; j++) begin
          ph_r[l][j] <= $signed(t_i[j][qvr_pkg::TW-1:qvr_pkg::SPL]) * q_i[COEF[l][j]];
          pl_r[l][j] <= $signed({1'b0, t_i[j][qvr_pkg::SPL-1:0]}) * q_i[COEF[l][j]];
        end
      end
      n1_r <= n_i;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [qvr_pkg::PW-1:0] hi, lo, sum;
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        for (int j = 0; j < 4; j++) begin
          hi  = qvr_pkg::PW'(ph_r[l][j]);
          lo  = qvr_pkg::PW'(pl_r[l][j]);
          sum = (hi <<< qvr_pkg::SPL) + lo;
          term_r[l][j] <= NEG[l][j] ? -sum : sum;
        end
      end
      n2_r <= n1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        p_r[l] <= (term_r[l][0] + term_r[l][1]) + (term_r[l][2] + term_r[l][3]);
      end
      n3_r <= n2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.vld <= 1'b0;
      ctl2_r.vld <= 1'b0;
      ctl3_r.vld <= 1'b0;
    end else if (en) begin
      ctl1_r.vld <= ctl_i.vld;
      ctl2_r.vld <= ctl1_r.vld;
      ctl3_r.vld <= ctl2_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r.zero <= ctl_i.zero;
      ctl2_r.zero <= ctl1_r.zero;
      ctl3_r.zero <= ctl2_r.zero;
    end
  end

  assign p_o   = p_r;
  assign n_o   = n3_r;
  assign ctl_o = ctl3_r;

endmodule

@@ hdl/qvr_div.sv @@
// Rounded division by the squared norm with saturation: a setup stage, one
// stage per quotient bit for three lanes, and the result register. Depends on qvr_pkg.
module qvr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic signed [qvr_pkg::PW-1:0] p_i [3],
  input  logic        [qvr_pkg::NW-1:0] n_i,
  input  qvr_pkg::qvr_ctl_t             ctl_i,
  output logic        [qvr_pkg::QW-1:0] res_o [3],
  output qvr_pkg::qvr_ctl_t             ctl_o
);

  localparam int QB   = qvr_pkg::QB;
  localparam int NUMW = qvr_pkg::NUMW;
  localparam int DW   = qvr_pkg::DW;
  localparam int QW   = qvr_pkg::QW;

  logic [NUMW-1:0]   rem_r [QB+1][3];
  logic [QB-1:0]     quo_r [QB+1][3];
  logic              neg_r [QB+1][3];
  logic              sat_r [QB+1][3];
  logic [DW-1:0]     den_r [QB+1];
  logic              zero_r [QB+1];
  logic              vld_r [QB+1];
  logic [QW-1:0]     res_r [3];
  qvr_pkg::qvr_ctl_t ctlo_r;

  always_ff @(posedge clk) begin
    logic signed [qvr_pkg::PW-1:0] mag;
    logic [NUMW-1:0]               num, dsh;
    logic [QB-1:0]                 q;
    if (en) begin
      // Setup: dividend 2|P| + N, divisor 2N, and the early overflow test.
      dsh = NUMW'({n_i, 1'b0}) << QB;
      for (int l = 0; l < 3; l++) begin
        mag = p_i[l][qvr_pkg::PW-1] ? -p_i[l] : p_i[l];
        num = NUMW'({mag[qvr_pkg::MAGW-1:0], 1'b0}) + NUMW'(n_i);
        rem_r[0][l] <= num;
        quo_r[0][l] <= '0;
        neg_r[0][l] <= p_i[l][qvr_pkg::PW-1];
        sat_r[0][l] <= num >= dsh;
      end
      den_r[0]  <= {n_i, 1'b0};
      zero_r[0] <= ctl_i.zero;

      // One quotient bit per stage, most significant bit first.
      for (int k = 0; k < QB; k++) begin
        dsh = NUMW'(den_r[k]) << (QB - 1 - k);
        for (int l = 0; l < 3; l++) begin
          if (rem_r[k][l] >= dsh) begin
            rem_r[k+1][l] <= rem_r[k][l] - dsh;
            quo_r[k+1][l] <= quo_r[k][l] | (QB'(1) << (QB - 1 - k));
          end else begin
            rem_r[k+1][l] <= rem_r[k][l];
            quo_r[k+1][l] <= quo_r[k][l];
          end
          neg_r[k+1][l] <= neg_r[k][l];
          sat_r[k+1][l] <= sat_r[k][l];
        end
        den_r[k+1]  <= den_r[k];
        zero_r[k+1] <= zero_r[k];
      end

      // Apply sign and clamp; a zero quaternion forces a zero vector.
      for (int l = 0; l < 3; l++) begin
        q = quo_r[QB][l];
        if (zero_r[QB]) begin
          res_r[l] <= '0;
        end else if (neg_r[QB][l]) begin
          if (sat_r[QB][l] || (q > (QB'(1) << (QW - 1)))) begin
            res_r[l] <= {1'b1, {(QW-1){1'b0}}};
          end else begin
            res_r[l] <= QW'(-q);
          end
        end else begin
          if (sat_r[QB][l] || (q > QB'({1'b0, {(QW-1){1'b1}}}))) begin
            res_r[l] <= {1'b0, {(QW-1){1'b1}}};
          end else begin
            res_r[l] <= QW'(q);
          end
        end
      end
      ctlo_r.zero <= zero_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QB; k++) begin
        vld_r[k] <= 1'b0;
      end
      ctlo_r.vld <= 1'b0;
    end else if (en) begin
      vld_r[0] <= ctl_i.vld;
      for (int k = 0; k < QB; k++) begin
        vld_r[k+1] <= vld_r[k];
      end
      ctlo_r.vld <= vld_r[QB];
    end
  end

  assign res_o = res_r;
  assign ctl_o = ctlo_r;

endmodule

@@ hdl/quaternion_vector_rotation.sv @@
// Quaternion vector rotation, q * (0,v) * conj(q) / |q|^2, saturated Q16.16.
// One request is taken every cycle while the result channel is not stalled,
// and the 33 one-bit divider stages set the depth.
// rst_n is synchronous and clears only valid bits; data registers keep content.
// Uses qvr_pkg, qvr_mult, qvr_rot and qvr_div.
module quaternion_vector_rotation (
  input  logic         clk,
  input  logic         rst_n,
  // Input channel.
  input  logic         in_tvalid,
  output logic         in_tready,
  // quat_w[31:0], quat_x[63:32], quat_y[95:64], quat_z[127:96],
  // vec_x[159:128], vec_y[191:160], vec_z[223:192]
  input  logic [223:0] in_tdata,
  // Result channel.
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]  out_tdata,
  // zero_norm_error[0]
  output logic         out_tuser
);

  logic signed [qvr_pkg::QW-1:0] q_in [4];
  logic signed [qvr_pkg::QW-1:0] v_in [3];
  logic signed [qvr_pkg::TW-1:0] t_m [4];
  logic        [qvr_pkg::NW-1:0] n_m, n_r;
  logic signed [qvr_pkg::QW-1:0] q_m [4];
  logic signed [qvr_pkg::PW-1:0] p_r [3];
  logic        [qvr_pkg::QW-1:0] res [3];
  qvr_pkg::qvr_ctl_t             ctl_m, ctl_rt, ctl_d;
  logic                          en;

  // The whole pipeline moves as one: it advances whenever the result
  // register is empty or being drained, so a stall freezes every stage and
  // nothing is dropped or duplicated. Bubbles travel as cleared valid bits.
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  for (genvar k = 0; k < 4; k++) begin : g_q
    assign q_in[k] = in_tdata[k*qvr_pkg::QW +: qvr_pkg::QW];
  end
  for (genvar k = 0; k < 3; k++) begin : g_v
    assign v_in[k] = in_tdata[(k+4)*qvr_pkg::QW +: qvr_pkg::QW];
  end

  // Products, first Hamilton product and squared norm (2 stages).
  qvr_mult u_mult (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_tvalid),
    .q_i    (q_in),
    .v_i    (v_in),
    .t_o    (t_m),
    .n_o    (n_m),
    .q_o    (q_m),
    .ctl_o  (ctl_m)
  );

  // Second Hamilton product, exact 100-bit numerators (3 stages).
  qvr_rot u_rot (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .t_i   (t_m),
    .n_i   (n_m),
    .q_i   (q_m),
    .ctl_i (ctl_m),
    .p_o   (p_r),
    .n_o   (n_r),
    .ctl_o (ctl_rt)
  );

  // Round-to-nearest division by the norm and saturation (35 stages, the
  // last of which is the output register).
  qvr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .p_i   (p_r),
    .n_i   (n_r),
    .ctl_i (ctl_rt),
    .res_o (res),
    .ctl_o (ctl_d)
  );

  assign out_tvalid = ctl_d.vld;
  assign out_tuser  = ctl_d.zero;
  assign out_tdata  = {res[2], res[1], res[0]};

  // A zero-norm result carries a zero vector.
  a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("zero-norm result with nonzero vector");

  // Reset empties the pipeline.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result register holds the pipeline back from the input.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while pipeline stalled");

endmodule

@@ tb/qvr_checker.sv @@
// Checker for the quaternion vector rotation block: watches both channels,
// predicts each rotated vector and compares it with the block's result.
// Depends on nothing but the channel signals handed in by the testbench top.
`timescale 1ns / 100ps
module qvr_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [223:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  input  logic         out_tuser,
  output int           fail_count,
  output int           pending_count
);

  typedef struct packed {
    logic        zero_err;
    logic [31:0] rz;
    logic [31:0] ry;
    logic [31:0] rx;
  } rotated_t;

  rotated_t rotated_q[$];

  // Rounds p / n to nearest with ties away from zero, then saturates to Q16.16.
  function automatic logic [31:0] round_sat(logic signed [127:0] p, logic signed [127:0] n);
    logic [127:0] mag;
    logic [127:0] quo;
    logic         neg;
    neg = p < 0;
    mag = neg ? -p : p;
    quo = (2 * mag + n) / (2 * n);
    if (!neg) begin
      if (quo > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return quo[31:0];
    end
    if (quo > 128'h8000_0000) return 32'h8000_0000;
    return -quo[31:0];
  endfunction

  function automatic rotated_t rotate_vector(logic [223:0] d);
    logic signed [127:0] qw, qx, qy, qz, vx, vy, vz;
    logic signed [127:0] n, t0, t1, t2, t3, r1, r2, r3;
    rotated_t res;
    qw = $signed(d[31:0]);    qx = $signed(d[63:32]);
    qy = $signed(d[95:64]);   qz = $signed(d[127:96]);
    vx = $signed(d[159:128]); vy = $signed(d[191:160]); vz = $signed(d[223:192]);
    n = qw * qw + qx * qx + qy * qy + qz * qz;
    if (n == 0) begin
      res = '0;
      res.zero_err = 1'b1;
      return res;
    end
    t0 = -(qx * vx + qy * vy + qz * vz);
    t1 = qw * vx + qy * vz - qz * vy;
    t2 = qw * vy - qx * vz + qz * vx;
    t3 = qw * vz + qx * vy - qy * vx;
    r1 = -t0 * qx + t1 * qw - t2 * qz + t3 * qy;
    r2 = -t0 * qy + t1 * qz + t2 * qw - t3 * qx;
    r3 = -t0 * qz - t1 * qy + t2 * qx + t3 * qw;
    res.rx = round_sat(r1, n);
    res.ry = round_sat(r2, n);
    res.rz = round_sat(r3, n);
    res.zero_err = 1'b0;
    return res;
  endfunction

  initial fail_count = 0;
  assign pending_count = rotated_q.size();

  always @(posedge clk) begin
    rotated_t want;
    int       errs;
    errs = 0;
    if (rst_n && in_tvalid && in_tready) rotated_q.push_back(rotate_vector(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      if (rotated_q.size() == 0) begin
        $error("result with no request outstanding");
        errs++;
      end else begin
        want = rotated_q.pop_front();
        if (want.rx !== out_tdata[31:0]) begin
          $error("out_x expected %h got %h", want.rx, out_tdata[31:0]);
          errs++;
        end
        if (want.ry !== out_tdata[63:32]) begin
          $error("out_y expected %h got %h", want.ry, out_tdata[63:32]);
          errs++;
        end
        if (want.rz !== out_tdata[95:64]) begin
          $error("out_z expected %h got %h", want.rz, out_tdata[95:64]);
          errs++;
        end
        if (want.zero_err !== out_tuser) begin
          $error("zero_norm_error expected %b got %b", want.zero_err, out_tuser);
          errs++;
        end
      end
    end
    if (errs != 0) fail_count <= fail_count + errs;
  end

endmodule

@@ tb/testbench.sv @@
// Testbench top for quaternion_vector_rotation: drives requests with random
// idling on both channels and reports the verdict. Uses qvr_checker.
`timescale 1ns / 100ps
module testbench;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [223:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic         out_tuser;
  int           fail_count;
  int           pending_count;

  // Idle percentages of each side; the phase changes them.
  int send_idle = 19;
  int recv_idle = 62;
  int idle_cycles = 0;
  bit timed_out = 0;

  localparam int LATENCY = 40;
  localparam int WATCHDOG = 5000;

  always #5 clk = ~clk;

  quaternion_vector_rotation i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  qvr_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // The receiver stalls at random on each falling edge.
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle);

  // The watchdog counts cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // A random component: mostly moderate values, sometimes the extremes.
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(3) - 2;
      4, 5: return $urandom;
      default: return {{3{$urandom_range(1) ? 1'b1 : 1'b0}}, 29'($urandom)};
    endcase
  endfunction

  // Sends one request; random idle cycles come before valid is raised, and
  // valid stays high until the request is accepted. Valid is left high so a
  // following request can go out back to back.
  task automatic send(logic [223:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_item(logic [31:0] w, x, y, z, vx, vy, vz);
    send({vz, vy, vx, z, y, x, w});
  endtask

  task automatic send_random(int count);
    logic [31:0] c [7];
    repeat (count) begin
      foreach (c[k]) c[k] = rand_comp();
      // A zero quaternion now and then.
      if ($urandom_range(49) == 0) begin
        c[0] = 0; c[1] = 0; c[2] = 0; c[3] = 0;
      end
      send_item(c[0], c[1], c[2], c[3], c[4], c[5], c[6]);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: identity, the zero quaternion, extremes, saturation.
    send_item(32'h4000_0000, 0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
    send_item(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    send_item(0, 0, 0, 0, 0, 0, 0);
    send_item(0, 32'h4000_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(0, 0, 32'h4000_0000, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(0, 0, 0, 32'h4000_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    // Tiny quaternions with a large vector: a component can rotate past the range.
    send_item(1, 1, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(1, 0, 0, 0, 32'hFFFF_FFFF, 32'h1, 32'h0);
    // Rounding cases: odd vector components with small and large norms.
    send_item(1, 1, 0, 0, 1, 1, 1);
    send_item(0, 0, 0, 1, 32'hFFFF_FFFF, 3, 32'hFFFF_FFFD);
    send_item(2, 1, 1, 1, 5, 32'hFFFF_FFFB, 7);
    send_item(32'h2D41_3CCD, 0, 0, 32'h2D41_3CCD, 32'h0001_0000, 0, 0);

    // Pause until every expected result is in.
    drain();

    send_random(550);
    send_idle = 62;
    recv_idle = 19;
    send_random(550);
    send_idle = 0;
    recv_idle = 0;
    send_random(550);

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
